[design/icmp_efr_pkg.sv]
// Package for the ICMP echo reply frame filter.
// Holds verdict codes, protocol constants and the result struct.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package icmp_efr_pkg;

  // Frame layout and protocol constants
  localparam logic [15:0] ETH_HDR_BYTES    = 16'd14;
  localparam logic [15:0] MIN_IP_HDR_BYTES = 16'd20;
  localparam logic [15:0] ICMP_HDR_BYTES   = 16'd8;
  localparam logic [15:0] ETHERTYPE_IPV4   = 16'h0800;
  localparam logic [7:0]  PROTO_ICMP       = 8'd1;
  localparam logic [7:0]  ICMP_ECHO_REPLY  = 8'd0;
  localparam logic [15:0] ECHO_ID_RESET    = 16'd1234;

  // Verdict codes, in check order
  typedef enum logic [2:0] {
    VERDICT_ACCEPT    = 3'd0,
    VERDICT_SHORT_ETH = 3'd1,
    VERDICT_NOT_IPV4  = 3'd2,
    VERDICT_SHORT_IP  = 3'd3,
    VERDICT_NOT_ICMP  = 3'd4,
    VERDICT_BAD_IHL   = 3'd5,
    VERDICT_NO_MATCH  = 3'd6
  } verdict_t;

  // One result item
  typedef struct packed {
    logic        stored;
    logic [4:0]  device_slot;
    logic [31:0] source_ip;
    logic [47:0] source_mac;
    verdict_t    verdict;
  } result_t;

endpackage

`default_nettype wire

[design/icmp_efr_parse.sv]
// Frame parser: byte counter, header captures, end-of-frame verdict
// and device slot allocation. Depends on icmp_efr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module icmp_efr_parse
  import icmp_efr_pkg::*;
#(
  parameter int TABLE_SLOTS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        step,
  input  wire logic [7:0]  frame_byte,
  input  wire logic        frame_end,
  input  wire logic [15:0] expected_echo_id,
  output result_t          res
);

  localparam logic [5:0] SLOTS = 6'(TABLE_SLOTS);

  logic [15:0] byte_position, byte_position_next;
  logic [47:0] mac_capture, mac_capture_next;
  logic [15:0] ethertype_capture, ethertype_capture_next;
  logic [3:0]  header_words, header_words_next;
  logic [7:0]  protocol_capture, protocol_capture_next;
  logic [31:0] ip_capture, ip_capture_next;
  logic [7:0]  icmp_type_capture, icmp_type_capture_next;
  logic [15:0] icmp_id_capture, icmp_id_capture_next;
  logic [5:0]  devices_found;

  logic [15:0] icmp_at;
  logic [15:0] ihl_bytes;
  logic [15:0] need_len;
  verdict_t    verdict;
  logic        take_slot;

  // Captures for the current byte; counter saturates and stops captures
  always_comb begin
    byte_position_next     = byte_position;
    mac_capture_next       = mac_capture;
    ethertype_capture_next = ethertype_capture;
    header_words_next      = header_words;
    protocol_capture_next  = protocol_capture;
    ip_capture_next        = ip_capture;
    icmp_type_capture_next = icmp_type_capture;
    icmp_id_capture_next   = icmp_id_capture;
    icmp_at = ETH_HDR_BYTES + {10'd0, header_words, 2'b00};
    if (byte_position != 16'hFFFF) begin
      if (byte_position >= 16'd6 && byte_position <= 16'd11) begin
        mac_capture_next = {mac_capture[39:0], frame_byte};
      end else if (byte_position == 16'd12 || byte_position == 16'd13) begin
        ethertype_capture_next = {ethertype_capture[7:0], frame_byte};
      end else if (byte_position == 16'd14) begin
        header_words_next = frame_byte[3:0];
      end else if (byte_position == 16'd23) begin
        protocol_capture_next = frame_byte;
      end else if (byte_position >= 16'd26 && byte_position <= 16'd29) begin
        ip_capture_next = {ip_capture[23:0], frame_byte};
      end
      if (byte_position > 16'd14) begin
        if (byte_position == icmp_at) begin
          icmp_type_capture_next = frame_byte;
        end else if (byte_position == icmp_at + 16'd4 ||
                     byte_position == icmp_at + 16'd5) begin
          icmp_id_capture_next = {icmp_id_capture[7:0], frame_byte};
        end
      end
      byte_position_next = byte_position + 16'd1;
    end
  end

  // Verdict from the captures including this byte
  always_comb begin
    ihl_bytes = {10'd0, header_words_next, 2'b00};
    need_len  = ETH_HDR_BYTES + ihl_bytes + ICMP_HDR_BYTES;
    if (byte_position_next < ETH_HDR_BYTES) begin
      verdict = VERDICT_SHORT_ETH;
    end else if (ethertype_capture_next != ETHERTYPE_IPV4) begin
      verdict = VERDICT_NOT_IPV4;
    end else if (byte_position_next < ETH_HDR_BYTES + MIN_IP_HDR_BYTES) begin
      verdict = VERDICT_SHORT_IP;
    end else if (protocol_capture_next != PROTO_ICMP) begin
      verdict = VERDICT_NOT_ICMP;
    end else if (ihl_bytes < MIN_IP_HDR_BYTES || byte_position_next < need_len) begin
      verdict = VERDICT_BAD_IHL;
    end else if (icmp_type_capture_next != ICMP_ECHO_REPLY ||
                 icmp_id_capture_next != expected_echo_id) begin
      verdict = VERDICT_NO_MATCH;
    end else begin
      verdict = VERDICT_ACCEPT;
    end
  end

  // Slot allocation and result fields
  always_comb begin
    take_slot           = (verdict == VERDICT_ACCEPT) && (devices_found < SLOTS);
    res.verdict         = verdict;
    res.source_mac      = mac_capture_next;
    res.source_ip       = ip_capture_next;
    res.stored          = take_slot;
    res.device_slot     = take_slot ? devices_found[4:0] : 5'd0;
  end

  // Frame state: cleared at frame end
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position     <= '0;
      mac_capture       <= '0;
      ethertype_capture <= '0;
      header_words      <= '0;
      protocol_capture  <= '0;
      ip_capture        <= '0;
      icmp_type_capture <= '0;
      icmp_id_capture   <= '0;
    end else if (step) begin
      if (frame_end) begin
        byte_position     <= '0;
        mac_capture       <= '0;
        ethertype_capture <= '0;
        header_words      <= '0;
        protocol_capture  <= '0;
        ip_capture        <= '0;
        icmp_type_capture <= '0;
        icmp_id_capture   <= '0;
      end else begin
        byte_position     <= byte_position_next;
        mac_capture       <= mac_capture_next;
        ethertype_capture <= ethertype_capture_next;
        header_words      <= header_words_next;
        protocol_capture  <= protocol_capture_next;
        ip_capture        <= ip_capture_next;
        icmp_type_capture <= icmp_type_capture_next;
        icmp_id_capture   <= icmp_id_capture_next;
      end
    end
  end

  // Device table fill count, kept across frames
  always_ff @(posedge clk) begin
    if (rst) begin
      devices_found <= '0;
    end else if (step && frame_end && take_slot) begin
      devices_found <= devices_found + 6'd1;
    end
  end

  // Checks
  a_clear_after_end: assert property (@(posedge clk) disable iff (rst)
    step && frame_end |=> byte_position == 16'd0 && mac_capture == 48'd0)
    else $error("frame state not cleared after frame end");

  a_stored_accepted: assert property (@(posedge clk) disable iff (rst)
    res.stored |-> res.verdict == VERDICT_ACCEPT)
    else $error("slot given to a rejected frame");

  a_table_bound: assert property (@(posedge clk) disable iff (rst)
    devices_found <= SLOTS)
    else $error("device count beyond table size");

  a_full_no_store: assert property (@(posedge clk) disable iff (rst)
    step && frame_end && !take_slot |=> devices_found == $past(devices_found))
    else $error("device count moved without a stored reply");

endmodule

`default_nettype wire

[design/icmp_echo_reply_frame_filter.sv]
// ICMP echo reply frame filter, top level: input register, parser,
// result register and the echo id register. Depends on icmp_efr_pkg
// and icmp_efr_parse.
//
// Usage: frame bytes enter on the s_axis channel, one byte per item,
// s_axis_tlast on the last byte of a frame. Each frame end yields one
// result item on m_axis: verdict, source MAC and IP, device slot and
// stored flag. Other bytes yield nothing.
// cfg_wr_en / cfg_wr_data write the expected echo identifier (reset 1234);
// write it only while the block is idle.
// Throughput: one byte per cycle unless a last byte waits on m_axis,
// set by the single capture/verdict pass from input to result register.
// A last byte's result is registered after it leaves the input register.
// Reset clears captures, the byte counter and the device count.
// When m_axis stalls, the result register holds; non-last bytes still
// advance, and a last byte waits in the input register, with s_axis_tready
// low, until the result register frees.
`timescale 1ns / 1ps
`default_nettype none

module icmp_echo_reply_frame_filter
  import icmp_efr_pkg::*;
#(
  parameter int TABLE_SLOTS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,  // [7:0] frame_byte
  input  wire logic        s_axis_tlast,  // frame_end
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [2:0] verdict, [50:3] source_mac, [82:51] source_ip,
  // [87:83] device_slot, [88] stored, [95:89] zero
  output logic [95:0]      m_axis_tdata,
  input  wire logic        cfg_wr_en,
  input  wire logic [15:0] cfg_wr_data
);

  logic        in_valid;
  logic [7:0]  in_byte;
  logic        in_last;
  logic        out_free;
  logic        process;
  logic [15:0] expected_echo_id;
  result_t     res;

  // Handshake control
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign process       = in_valid && (!in_last || out_free);
  assign s_axis_tready = !in_valid || process;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      expected_echo_id <= ECHO_ID_RESET;
    end else if (cfg_wr_en) begin
      expected_echo_id <= cfg_wr_data;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte <= s_axis_tdata;
      in_last <= s_axis_tlast;
    end
  end

  icmp_efr_parse #(
    .TABLE_SLOTS (TABLE_SLOTS)
  ) u_parse (
    .clk              (clk),
    .rst              (rst),
    .step             (process),
    .frame_byte       (in_byte),
    .frame_end        (in_last),
    .expected_echo_id (expected_echo_id),
    .res              (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (process && in_last) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (process && in_last) begin
      m_axis_tdata <= {7'd0, res.stored, res.device_slot, res.source_ip,
                       res.source_mac, res.verdict};
    end
  end

endmodule

`default_nettype wire
